@@ rtl/sialu_pkg.sv @@
// Package for the signed integer ALU with GCD and LCM.
// Holds operation codes and the default data width; no dependencies.
package sialu_pkg;

    localparam int DataWidthDefault = 64;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MOD = 3'd4,
        OP_GCD = 3'd5,
        OP_LCM = 3'd6,
        OP_NOP = 3'd7
    } t_op;

endpackage

@@ rtl/sialu_divider.sv @@
// Restoring bit-serial unsigned divider, one quotient bit a cycle.
// Depends on nothing outside itself.
module sialu_divider #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DATA_WIDTH-1:0] i_dividend,
    input  logic [DATA_WIDTH-1:0] i_divisor,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_quotient,
    output logic [DATA_WIDTH-1:0] o_remainder
);
    localparam int CntW = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] r_quo, r_rem, r_div;
    logic [CntW-1:0]       r_cnt;
    logic                  r_busy, r_done;
    logic [DATA_WIDTH:0]   n_trial;
    logic [DATA_WIDTH:0]   n_shift;

    // One step: shift the next dividend bit into the partial remainder.
    always_comb begin
        n_shift = {r_rem, r_quo[DATA_WIDTH-1]};
        n_trial = n_shift - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // Done pulses for one cycle after the last quotient bit.
            r_done <= r_busy && !i_start && (r_cnt == CntW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(DATA_WIDTH);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                if (!n_trial[DATA_WIDTH]) begin
                    r_rem <= n_trial[DATA_WIDTH-1:0];
                    r_quo <= {r_quo[DATA_WIDTH-2:0], 1'b1};
                end else begin
                    r_rem <= n_shift[DATA_WIDTH-1:0];
                    r_quo <= {r_quo[DATA_WIDTH-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
endmodule

@@ rtl/signed_integer_alu_gcd_lcm_unit.sv @@
// Top level of the signed integer ALU with Euclidean GCD and LCM.
// Depends on sialu_pkg and sialu_divider.
//
// Usage: raise start with i_cmd, i_operand_a and i_operand_b while
// busy is low; the word is taken at that clock edge. busy stays high
// until the result has been shown. The result appears on o_result for
// exactly one cycle with o_valid high; the receiver cannot stall it.
// Add, sub, the unused code, and div or mod with a zero operand go from
// the accepting edge straight to the output state. Mul runs its
// shift-and-add loop. Div and mod run the bit-serial divider. GCD runs
// one division per Euclid step; the number of steps depends on the
// operands (at most about 1.44*DATA_WIDTH). LCM runs the multiply, the
// GCD and one more division. Every word gives exactly one result, and
// the next word can be taken at the edge that takes the result.
// Reset (synchronous, active low) returns the sequencer to idle and
// drops o_valid and busy; a word in flight is lost.
module signed_integer_alu_gcd_lcm_unit #(
    parameter int DATA_WIDTH = sialu_pkg::DataWidthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_cmd,
    input  logic signed [63:0] i_operand_a,
    input  logic signed [63:0] i_operand_b,
    output logic        o_valid,
    output logic signed [63:0] o_result
);
    localparam int CntW = $clog2(DATA_WIDTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_DIV, S_GCD, S_LCMDIV, S_OUT
    } t_state;

    t_state                r_state;
    sialu_pkg::t_op        r_op;
    logic [DATA_WIDTH-1:0] r_x, r_y, r_acc, r_mcand, r_mplier;
    logic [DATA_WIDTH-1:0] r_res;
    logic                  r_sneg, r_wait, r_busy, r_valid;
    logic [CntW-1:0]       r_cnt;

    logic                  n_dstart, d_done;
    logic [DATA_WIDTH-1:0] n_dnd, n_dsr, d_quo, d_rem;
    logic [DATA_WIDTH-1:0] w_a, w_b, w_ma, w_mb, w_pmag;

    assign w_a  = i_operand_a[DATA_WIDTH-1:0];
    assign w_b  = i_operand_b[DATA_WIDTH-1:0];
    assign w_ma = w_a[DATA_WIDTH-1] ? -w_a : w_a;
    assign w_mb = w_b[DATA_WIDTH-1] ? -w_b : w_b;
    assign w_pmag = r_acc[DATA_WIDTH-1] ? -r_acc : r_acc;

    sialu_divider #(.DATA_WIDTH(DATA_WIDTH)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_dstart),
        .i_dividend (n_dnd),
        .i_divisor  (n_dsr),
        .o_done     (d_done),
        .o_quotient (d_quo),
        .o_remainder(d_rem)
    );

    // Divider launch: in a division state, with r_wait low and a nonzero divisor.
    always_comb begin
        n_dstart = 1'b0;
        n_dnd    = r_x;
        n_dsr    = r_y;
        if (!r_wait && (r_state == S_DIV || r_state == S_GCD
                        || r_state == S_LCMDIV) && r_y != '0) begin
            n_dstart = 1'b1;
        end
    end

    // Sequencer with its registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_wait  <= 1'b0;
        end else begin
            r_valid <= (r_state == S_OUT);
            case (r_state)
                S_IDLE: begin
                    if (start && !r_busy) begin
                        r_busy   <= 1'b1;
                        r_op     <= sialu_pkg::t_op'(i_cmd);
                        r_x      <= w_ma;
                        r_y      <= w_mb;
                        r_sneg   <= w_a[DATA_WIDTH-1] ^ w_b[DATA_WIDTH-1];
                        r_acc    <= '0;
                        r_mcand  <= w_a;
                        r_mplier <= w_b;
                        r_cnt    <= CntW'(DATA_WIDTH);
                        r_wait   <= 1'b0;
                        case (sialu_pkg::t_op'(i_cmd))
                            sialu_pkg::OP_ADD: begin
                                r_res <= w_a + w_b;
                                r_state <= S_OUT;
                            end
                            sialu_pkg::OP_SUB: begin
                                r_res <= w_a - w_b;
                                r_state <= S_OUT;
                            end
                            sialu_pkg::OP_MUL, sialu_pkg::OP_LCM: r_state <= S_MUL;
                            sialu_pkg::OP_DIV, sialu_pkg::OP_MOD: begin
                                if (w_a == '0 || w_b == '0) begin
                                    r_res <= '0;
                                    r_state <= S_OUT;
                                end else begin
                                    r_state <= S_DIV;
                                end
                            end
                            sialu_pkg::OP_GCD: r_state <= S_GCD;
                            default: begin
                                r_res <= '0;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                // Shift-and-add multiply, low DATA_WIDTH bits.
                S_MUL: begin
                    if (r_mplier[0]) r_acc <= r_acc + r_mcand;
                    r_mcand  <= {r_mcand[DATA_WIDTH-2:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[DATA_WIDTH-1:1]};
                    r_cnt    <= r_cnt - 1'b1;
                    if (r_cnt == CntW'(1)) begin
                        if (r_op == sialu_pkg::OP_LCM) begin
                            r_state <= S_GCD;
                        end else begin
                            r_state <= S_OUT;
                            r_res   <= (r_mplier[0] ? r_acc + r_mcand : r_acc);
                        end
                    end
                end
                S_DIV: begin
                    if (n_dstart) r_wait <= 1'b1;
                    if (d_done) begin
                        r_state <= S_OUT;
                        if (r_op == sialu_pkg::OP_DIV)
                            r_res <= r_sneg ? -d_quo : d_quo;
                        else
                            r_res <= d_rem;
                    end
                end
                // Euclid: one division per step until the divisor is zero.
                S_GCD: begin
                    if (n_dstart) r_wait <= 1'b1;
                    if (r_y == '0 && !r_wait) begin
                        if (r_op == sialu_pkg::OP_GCD) begin
                            r_res   <= r_x;
                            r_state <= S_OUT;
                        end else if (r_x == '0 || r_acc == '0) begin
                            r_res   <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_y     <= r_x;
                            r_x     <= w_pmag;
                            r_state <= S_LCMDIV;
                        end
                    end else if (d_done) begin
                        r_x    <= r_y;
                        r_y    <= d_rem;
                        r_wait <= 1'b0;
                    end
                end
                S_LCMDIV: begin
                    if (n_dstart) r_wait <= 1'b1;
                    if (d_done) begin
                        r_res   <= d_quo;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_busy  <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Multiply sign fix-up is applied when the product is shown.
    logic [DATA_WIDTH-1:0] w_out, w_mmag;
    assign w_mmag = r_res[DATA_WIDTH-1] ? -r_res : r_res;
    assign w_out  = (r_op == sialu_pkg::OP_MUL && r_res != '0)
                  ? (r_sneg ? -w_mmag : w_mmag) : r_res;

    logic [DATA_WIDTH-1:0] r_out;
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT) r_out <= w_out;
    end

    assign busy     = r_busy;
    assign o_valid  = r_valid;
    assign o_result = 64'(signed'(r_out));

`ifndef SYNTHESIS
    a_valid_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while still busy");
    a_start_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");
`endif
endmodule
